[design/velocity_to_drive_command_top_defines.svh]
// assertion macros shared by the velocity to drive command design
`ifndef VELOCITY_TO_DRIVE_COMMAND_TOP_DEFINES_SVH
`define VELOCITY_TO_DRIVE_COMMAND_TOP_DEFINES_SVH

// condition must hold at every edge out of reset
`define V2DC_ASSERT_HOLD(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error("v2dc: invariant violated");

// consequent must hold in the cycle after the antecedent
`define V2DC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("v2dc: sequence violated");

`endif

[design/v2dc_pkg.sv]
// shared types and constants of the velocity to drive command block
`default_nettype none
package v2dc_pkg;

  localparam int ANGLE_W    = 28;
  localparam int ATAN_N     = 24;
  localparam int GUARD_BITS = 8;
  localparam int CFG_W      = 16;
  localparam int LIM_W      = 15;

  // atan(2^-i) in q24, rounded to nearest
  localparam logic [23:0] ATAN_TAB [ATAN_N] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
    24'd1047214,  24'd524117,  24'd262123,  24'd131069,
    24'd65536,    24'd32768,   24'd16384,   24'd8192,
    24'd4096,     24'd2048,    24'd1024,    24'd512,
    24'd256,      24'd128,     24'd64,      24'd32,
    24'd16,       24'd8,       24'd4,       24'd2
  };

  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic [15:0]               INV_GAIN_Q16 = 16'd39797;
  localparam logic signed [14:0]        PI_Q12 = 15'sd12868;

  typedef enum logic [1:0] {
    CFG_MAX_SPEED = 2'd0,
    CFG_MAX_TURN  = 2'd1,
    CFG_GAIN      = 2'd2,
    CFG_STILL     = 2'd3
  } cfg_idx_e;

  localparam logic [LIM_W-1:0] RST_MAX_SPEED = 15'd512;
  localparam logic [LIM_W-1:0] RST_MAX_TURN  = 15'd4096;
  localparam logic [15:0]      RST_GAIN      = 16'd256;
  localparam logic [LIM_W-1:0] RST_STILL     = 15'd3;

  typedef struct packed {
    logic valid;
    logic zero;
  } v2dc_ctrl_t;

endpackage
`default_nettype wire

[design/velocity_to_drive_command_top.sv]
// velocity vector to drive command: fold, cordic cell chain, output stage
//
// s_axis carries one velocity sample per beat, vel_x in the low half of
// tdata and vel_y above it. m_axis returns one beat per sample with the
// clamped linear speed and the saturated yaw rate, in input order.
// the cfg port writes one register per cycle with cfg_we_i high: index 0
// max linear speed, 1 max turn rate, 2 heading gain, 3 still threshold.
// the chain is one fold stage, one cell per cordic rotation and three
// output stages; every stage holds one sample.
// throughput is one beat per cycle while the receiver does not stall.
// when the receiver stalls with a result waiting, the whole chain holds
// and s_axis_tready drops; it rises again in the cycle m_axis_tready
// takes the waiting beat. reset empties the chain and loads the register
// defaults (512, 4096, 256, 3); no clearing pass is needed.
`default_nettype none
module velocity_to_drive_command_top import v2dc_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int VEL_WIDTH     = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // vel_x, vel_y, zero fill to whole bytes
  input  wire logic [((2*VEL_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // linear_speed [14:0], turn_rate [30:15], zero [31]
  output logic [31:0]                               m_axis_tdata,
  input  wire logic                                 cfg_we_i,
  input  wire logic [1:0]                           cfg_addr_i,
  input  wire logic [CFG_W-1:0]                     cfg_wdata_i
);

  localparam int XW = VEL_WIDTH + 11;
  localparam int N  = CORDIC_STAGES;

  logic             adv;
  logic [LIM_W-1:0] max_speed_q, max_turn_q, still_q;
  logic [15:0]      gain_q;
  logic [LIM_W-1:0] speed;
  logic signed [15:0] turn;

  v2dc_ctrl_t                ctrl_s [N+1];
  logic signed [XW-1:0]      x_s    [N+1];
  logic signed [XW-1:0]      y_s    [N+1];
  logic signed [ANGLE_W-1:0] z_s    [N+1];

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= RST_MAX_SPEED;
      max_turn_q  <= RST_MAX_TURN;
      gain_q      <= RST_GAIN;
      still_q     <= RST_STILL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_MAX_SPEED: max_speed_q <= cfg_wdata_i[LIM_W-1:0];
        CFG_MAX_TURN:  max_turn_q  <= cfg_wdata_i[LIM_W-1:0];
        CFG_GAIN:      gain_q      <= cfg_wdata_i;
        CFG_STILL:     still_q     <= cfg_wdata_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  v2dc_fold #(.VW(VEL_WIDTH), .XW(XW)) u_fold (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (s_axis_tvalid),
    .vel_x_i    (s_axis_tdata[VEL_WIDTH-1:0]),
    .vel_y_i    (s_axis_tdata[2*VEL_WIDTH-1:VEL_WIDTH]),
    .ctrl_o     (ctrl_s[0]),
    .x_o        (x_s[0]),
    .y_o        (y_s[0]),
    .z_o        (z_s[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    v2dc_cordic_cell #(.XW(XW), .STAGE(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .ctrl_i (ctrl_s[g]),
      .x_i    (x_s[g]),
      .y_i    (y_s[g]),
      .z_i    (z_s[g]),
      .ctrl_o (ctrl_s[g+1]),
      .x_o    (x_s[g+1]),
      .y_o    (y_s[g+1]),
      .z_o    (z_s[g+1])
    );
  end

  v2dc_post #(.XW(XW)) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .ctrl_i      (ctrl_s[N]),
    .x_i         (x_s[N]),
    .z_i         (z_s[N]),
    .max_speed_i (max_speed_q),
    .max_turn_i  (max_turn_q),
    .gain_i      (gain_q),
    .still_i     (still_q),
    .valid_o     (m_axis_tvalid),
    .speed_o     (speed),
    .turn_o      (turn)
  );

  // y_s of the last cell is not needed past the chain
  logic unused_y;
  assign unused_y = ^y_s[N];

  assign m_axis_tdata = {unused_y & 1'b0, turn, speed};

  `include "velocity_to_drive_command_top_defines.svh"

  `V2DC_ASSERT_NEXT(a_stall_freeze, clk_i, rst_ni, !adv, $stable(ctrl_s[0]))
  `V2DC_ASSERT_HOLD(a_turn_range, clk_i, rst_ni, !m_axis_tvalid || (turn != 16'sh8000))

endmodule
`default_nettype wire

[design/v2dc_fold.sv]
// input stage: guard bits and quadrant fold into the right half plane
`default_nettype none
module v2dc_fold import v2dc_pkg::*; #(
  parameter int VW = 16,
  parameter int XW = VW + 11
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 adv_i,
  input  wire logic                 in_valid_i,
  input  wire logic [VW-1:0]        vel_x_i,
  input  wire logic [VW-1:0]        vel_y_i,
  output v2dc_ctrl_t                ctrl_o,
  output logic signed [XW-1:0]      x_o,
  output logic signed [XW-1:0]      y_o,
  output logic signed [ANGLE_W-1:0] z_o
);

  v2dc_ctrl_t                ctrl_q;
  logic signed [XW-1:0]      xs, ys, x_d, y_d, x_q, y_q;
  logic signed [ANGLE_W-1:0] z_d, z_q;

  assign xs = {{(XW-VW-GUARD_BITS){vel_x_i[VW-1]}}, vel_x_i, {GUARD_BITS{1'b0}}};
  assign ys = {{(XW-VW-GUARD_BITS){vel_y_i[VW-1]}}, vel_y_i, {GUARD_BITS{1'b0}}};

  always_comb begin
    x_d = xs;
    y_d = ys;
    z_d = '0;
    if (xs[XW-1]) begin
      if (!ys[XW-1]) begin
        x_d = ys;
        y_d = -xs;
        z_d = HALF_PI_Q24;
      end else begin
        x_d = -ys;
        y_d = xs;
        z_d = -HALF_PI_Q24;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (adv_i) begin
      ctrl_q.valid <= in_valid_i;
      ctrl_q.zero  <= (vel_x_i == '0) && (vel_y_i == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule
`default_nettype wire

[design/v2dc_cordic_cell.sv]
// one vectoring micro-rotation of the cordic chain
`default_nettype none
module v2dc_cordic_cell import v2dc_pkg::*; #(
  parameter int XW    = 27,
  parameter int STAGE = 0
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        adv_i,
  input  wire v2dc_ctrl_t                  ctrl_i,
  input  wire logic signed [XW-1:0]        x_i,
  input  wire logic signed [XW-1:0]        y_i,
  input  wire logic signed [ANGLE_W-1:0]   z_i,
  output v2dc_ctrl_t                       ctrl_o,
  output logic signed [XW-1:0]             x_o,
  output logic signed [XW-1:0]             y_o,
  output logic signed [ANGLE_W-1:0]        z_o
);

  localparam logic signed [ANGLE_W-1:0] ATAN_I =
    {{(ANGLE_W-24){1'b0}}, ATAN_TAB[STAGE]};

  v2dc_ctrl_t                ctrl_q;
  logic signed [XW-1:0]      dx, dy, x_d, y_d, x_q, y_q;
  logic signed [ANGLE_W-1:0] z_d, z_q;

  assign dx = y_i >>> STAGE;
  assign dy = x_i >>> STAGE;

  always_comb begin
    if (y_i[XW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN_I;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN_I;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (adv_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule
`default_nettype wire

[design/v2dc_post.sv]
// gain correction, bearing rounding, yaw gain and output clamps
`default_nettype none
module v2dc_post import v2dc_pkg::*; #(
  parameter int XW = 27
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       adv_i,
  input  wire v2dc_ctrl_t                 ctrl_i,
  input  wire logic signed [XW-1:0]       x_i,
  input  wire logic signed [ANGLE_W-1:0]  z_i,
  input  wire logic [LIM_W-1:0]           max_speed_i,
  input  wire logic [LIM_W-1:0]           max_turn_i,
  input  wire logic [15:0]                gain_i,
  input  wire logic [LIM_W-1:0]           still_i,
  output logic                            valid_o,
  output logic [LIM_W-1:0]                speed_o,
  output logic signed [15:0]              turn_o
);

  localparam int PW = XW + 17;
  localparam int MW = XW - 8;
  localparam int CW = (MW > LIM_W) ? MW : LIM_W;
  localparam logic [PW-1:0] MAG_RND = PW'(1) << 23;

  // stage 1: split gain product, rounded bearing
  v2dc_ctrl_t          c1_q;
  logic signed [XW:0]  hi_d, hi_q;
  logic [31:0]         lo_d, lo_q;
  logic signed [ANGLE_W-1:0] zr;
  logic signed [15:0]  b16;
  logic signed [14:0]  bear_d, bear_q;

  assign hi_d = $signed(x_i[XW-1:16]) * $signed({1'b0, INV_GAIN_Q16});
  assign lo_d = x_i[15:0] * INV_GAIN_Q16;
  assign zr   = z_i + ANGLE_W'(2048);
  assign b16  = zr[27:12];

  always_comb begin
    if (ctrl_i.zero) begin
      bear_d = '0;
    end else if (b16 > 16'sd12868) begin
      bear_d = PI_Q12;
    end else if (b16 < -16'sd12868) begin
      bear_d = -PI_Q12;
    end else begin
      bear_d = b16[14:0];
    end
  end

  // stage 2: magnitude sum, yaw product
  v2dc_ctrl_t          c2_q;
  logic [PW-1:0]       msum;
  logic [MW-1:0]       mag_d, mag_q;
  logic signed [31:0]  yprod_d, yprod_q;

  assign msum = {hi_q, 16'b0} + {{(PW-32){1'b0}}, lo_q} + MAG_RND;
  assign mag_d = (c1_q.zero || msum[PW-1]) ? '0 : msum[PW-2:24];
  assign yprod_d = bear_q * $signed({1'b0, gain_i});

  // stage 3: clamps
  logic [CW-1:0]       mag_w, max_w, still_w;
  logic [LIM_W-1:0]    speed_d, speed_q;
  logic signed [31:0]  yr;
  logic signed [23:0]  yaw, lim;
  logic signed [15:0]  turn_d, turn_q;
  logic                valid_q;

  assign mag_w   = CW'(mag_q);
  assign max_w   = CW'(max_speed_i);
  assign still_w = CW'(still_i);
  assign speed_d = (mag_w > max_w) ? max_speed_i : mag_w[LIM_W-1:0];
  assign yr      = yprod_q + 32'sd128;
  assign yaw     = yr[31:8];
  assign lim     = $signed({9'b0, max_turn_i});

  always_comb begin
    if (mag_w < still_w) begin
      turn_d = '0;
    end else if (yaw > lim) begin
      turn_d = lim[15:0];
    end else if (yaw < -lim) begin
      turn_d = -lim[15:0];
    end else begin
      turn_d = yaw[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q    <= '0;
      c2_q    <= '0;
      valid_q <= 1'b0;
    end else if (adv_i) begin
      c1_q    <= ctrl_i;
      c2_q    <= c1_q;
      valid_q <= c2_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      hi_q    <= hi_d;
      lo_q    <= lo_d;
      bear_q  <= bear_d;
      mag_q   <= mag_d;
      yprod_q <= yprod_d;
      speed_q <= speed_d;
      turn_q  <= turn_d;
    end
  end

  assign valid_o = valid_q;
  assign speed_o = speed_q;
  assign turn_o  = turn_q;

  `include "velocity_to_drive_command_top_defines.svh"

  `V2DC_ASSERT_HOLD(a_bear_range, clk_i, rst_ni, !c1_q.valid || (bear_q <= PI_Q12 && bear_q >= -PI_Q12))
  `V2DC_ASSERT_NEXT(a_zero_mag, clk_i, rst_ni, adv_i && c1_q.valid && c1_q.zero, mag_q == '0)

endmodule
`default_nettype wire

[tb/tb_velocity_to_drive_command_top.sv]
// self-checking testbench for velocity_to_drive_command_top: directed and random velocity beats
`timescale 1ns / 1ps
module tb_velocity_to_drive_command_top import v2dc_pkg::*; ();

  localparam int STAGES    = 16;
  localparam int VW        = 16;
  localparam int N_PHASE   = 8;
  localparam int PER_PHASE = 230;

  typedef struct {
    logic [14:0]        speed;
    logic signed [15:0] turn;
  } drive_cmd_t;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic               has_speed;
    logic               has_turn;
    logic [14:0]        speed;
    logic signed [15:0] turn;
  } stim_row_t;

  // expected values typed in only where the reset clamps settle them
  localparam int N_DIR = 22;
  localparam stim_row_t DIRECTED [N_DIR] = '{
    '{16'sd0,      16'sd0,      1'b1, 1'b1, 15'd0,   16'sd0},     // zero vector
    '{16'sd32767,  16'sd0,      1'b1, 1'b0, 15'd512, 16'sd0},
    '{16'sh8000,   16'sd0,      1'b1, 1'b1, 15'd512, 16'sd4096},  // negative x axis
    '{16'sd0,      16'sd32767,  1'b1, 1'b1, 15'd512, 16'sd4096},
    '{16'sd0,      16'sh8000,   1'b1, 1'b1, 15'd512, -16'sd4096},
    '{16'sd32767,  16'sd32767,  1'b1, 1'b0, 15'd512, 16'sd0},
    '{16'sh8000,   16'sh8000,   1'b1, 1'b1, 15'd512, -16'sd4096},
    '{16'sh8000,   16'sd32767,  1'b1, 1'b1, 15'd512, 16'sd4096},
    '{16'sd32767,  16'sh8000,   1'b1, 1'b0, 15'd512, 16'sd0},
    '{16'sh8000,   -16'sd1,     1'b1, 1'b1, 15'd512, -16'sd4096},
    '{16'sd1,      16'sd0,      1'b0, 1'b1, 15'd0,   16'sd0},     // below still threshold
    '{-16'sd1,     16'sd0,      1'b0, 1'b1, 15'd0,   16'sd0},
    '{16'sd0,      -16'sd1,     1'b0, 1'b1, 15'd0,   16'sd0},
    '{-16'sd1,     -16'sd1,     1'b0, 1'b1, 15'd0,   16'sd0},
    '{-16'sd256,   16'sd0,      1'b0, 1'b1, 15'd0,   16'sd4096},  // -1 m/s, bearing +pi
    '{16'sd3,      16'sd0,      1'b0, 1'b0, 15'd0,   16'sd0},
    '{16'sd2,      16'sd2,      1'b0, 1'b0, 15'd0,   16'sd0},
    '{16'sd256,    16'sd1,      1'b0, 1'b0, 15'd0,   16'sd0},
    '{-16'sd256,   16'sd1,      1'b0, 1'b0, 15'd0,   16'sd0},
    '{-16'sd256,   -16'sd1,     1'b0, 1'b0, 15'd0,   16'sd0},
    '{16'sd100,    -16'sd200,   1'b0, 1'b0, 15'd0,   16'sd0},
    '{-16'sd12345, 16'sd6789,   1'b0, 1'b0, 15'd0,   16'sd0}
  };

  localparam cfg_idx_e REG_ORDER [4] = '{CFG_MAX_SPEED, CFG_MAX_TURN, CFG_GAIN, CFG_STILL};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  // shadow of the block's registers
  longint speed_cap = RST_MAX_SPEED;
  longint turn_cap  = RST_MAX_TURN;
  longint yaw_gain  = RST_GAIN;
  longint still_thr = RST_STILL;

  drive_cmd_t cmd_pending_q [$];
  int         n_bad = 0;
  bit         no_idle = 1'b0;
  int         stall_left = 0;
  int         rx_roll;

  velocity_to_drive_command_top #(
    .CORDIC_STAGES(STAGES),
    .VEL_WIDTH    (VW)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // cordic vectoring, then speed clamp and gained, saturated bearing
  function automatic drive_cmd_t drive_command_of(logic signed [15:0] vx,
                                                  logic signed [15:0] vy);
    longint     x, y, z, dx, dy, t, mag, brg, yaw;
    int         i;
    drive_cmd_t c;
    x = longint'(vx) * 256;
    y = longint'(vy) * 256;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = longint'(HALF_PI_Q24);
      end else begin
        x = -y;
        y = t;
        z = -longint'(HALF_PI_Q24);
      end
    end
    for (i = 0; i < STAGES && i < ATAN_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TAB[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TAB[i]);
      end
    end
    if (vx == 0 && vy == 0) begin
      mag = 0;
      brg = 0;
    end else begin
      mag = (x * longint'(INV_GAIN_Q16) + (longint'(1) << 23)) >>> 24;
      if (mag < 0) mag = 0;
      brg = (z + (longint'(1) << 11)) >>> 12;
      if (brg > longint'(PI_Q12)) brg = longint'(PI_Q12);
      if (brg < -longint'(PI_Q12)) brg = -longint'(PI_Q12);
    end
    c.speed = 15'((mag > speed_cap) ? speed_cap : mag);
    if (mag < still_thr) begin
      yaw = 0;
    end else begin
      yaw = (brg * yaw_gain + 128) >>> 8;
      if (yaw > turn_cap) yaw = turn_cap;
      if (yaw < -turn_cap) yaw = -turn_cap;
    end
    c.turn = 16'(yaw);
    return c;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one velocity beat, held until taken; expectation queued on acceptance
  task automatic send_velocity(logic signed [15:0] vx, logic signed [15:0] vy,
                               bit has_speed, bit has_turn,
                               logic [14:0] speed, logic signed [15:0] turn);
    drive_cmd_t c;
    int         gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {vy, vx};
    do @(posedge clk_i); while (!s_axis_tready);
    c = drive_command_of(vx, vy);
    if (has_speed) c.speed = speed;
    if (has_turn) c.turn = turn;
    cmd_pending_q = {cmd_pending_q, c};
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (cmd_pending_q.size() != 0) @(posedge clk_i);
  endtask

  // all four registers, one per cycle, block idle
  task automatic write_limits(logic [15:0] spd, logic [15:0] trn, logic [15:0] gn,
                              logic [15:0] sth);
    logic [15:0] vals [4];
    vals = '{spd, trn, gn, sth};
    for (int k = 0; k < 4; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= REG_ORDER[k];
      cfg_wdata_i <= vals[k];
      @(posedge clk_i);
    end
    cfg_we_i  <= 1'b0;
    speed_cap = spd & 16'h7FFF;
    turn_cap  = trn & 16'h7FFF;
    yaw_gain  = gn;
    still_thr = sth & 16'h7FFF;
  endtask

  task automatic random_velocity(output logic signed [15:0] vx,
                                 output logic signed [15:0] vy);
    int kind, r;
    int corner [5];
    corner = '{-32768, -1, 0, 1, 32767};
    kind = $urandom_range(0, 9);
    r = (still_thr + 4 > 32767) ? 32767 : int'(still_thr) + 4;
    case (kind)
      4, 5: begin
        // around the still threshold
        vx = 16'($urandom_range(0, 2 * r) - r);
        vy = 16'($urandom_range(0, 2 * r) - r);
      end
      6: begin
        vx = 16'($urandom);
        vy = 16'($urandom_range(0, 2) - 1);
        if ($urandom_range(0, 1)) begin
          vy = vx;
          vx = 16'($urandom_range(0, 2) - 1);
        end
      end
      7: begin
        vx = 16'(corner[$urandom_range(0, 4)]);
        vy = 16'(corner[$urandom_range(0, 4)]);
      end
      8, 9: begin
        vx = 16'($urandom_range(0, 4096) - 2048);
        vy = 16'($urandom_range(0, 4096) - 2048);
      end
      default: begin
        vx = 16'($urandom);
        vy = 16'($urandom);
      end
    endcase
  endtask

  // receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (no_idle || rx_roll < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall_left    <= (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(7, 39);
      end
    end
  end

  // result beats against the oldest expectation
  always @(posedge clk_i) begin
    drive_cmd_t want;
    logic [14:0] got_speed;
    logic signed [15:0] got_turn;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_speed = m_axis_tdata[14:0];
      got_turn  = m_axis_tdata[30:15];
      if (cmd_pending_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("%0t: unexpected beat speed=%0d turn=%0d", $realtime, got_speed, got_turn);
      end else begin
        want = cmd_pending_q.pop_front();
        if (got_speed !== want.speed || got_turn !== want.turn) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: mismatch speed exp=%0d got=%0d, turn exp=%0d got=%0d",
                     $realtime, want.speed, got_speed, want.turn, got_turn);
        end
      end
    end
  end

  initial begin
    logic signed [15:0] vx, vy;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < N_DIR; n++)
      send_velocity(DIRECTED[n].vx, DIRECTED[n].vy, DIRECTED[n].has_speed,
                    DIRECTED[n].has_turn, DIRECTED[n].speed, DIRECTED[n].turn);

    for (int p = 0; p < N_PHASE; p++) begin
      drain();
      case (p)
        0: write_limits(16'd0, 16'd0, 16'd0, 16'd0);
        1: write_limits(16'd32767, 16'd32767, 16'd65535, 16'd32767);
        2: write_limits(16'd32767, 16'd32767, 16'd65535, 16'd0);
        3: write_limits(16'd32767, 16'd32767, 16'd256, 16'd3);
        default: write_limits(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)),
                              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 64)));
      endcase
      // some phases run back to back with no gaps on either side
      no_idle = (p == 3 || p == 6);
      for (int n = 0; n < PER_PHASE; n++) begin
        random_velocity(vx, vy);
        send_velocity(vx, vy, 1'b0, 1'b0, 15'd0, 16'sd0);
      end
    end

    drain();
    repeat (STAGES + 8) @(posedge clk_i);
    if (n_bad == 0 && cmd_pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[velocity_to_drive_command_top.f]
+incdir+design
design/v2dc_pkg.sv
design/v2dc_fold.sv
design/v2dc_cordic_cell.sv
design/v2dc_post.sv
design/velocity_to_drive_command_top.sv
tb/tb_velocity_to_drive_command_top.sv
